// ===== rtl/ray_cube_hit_test_core_defines.svh =====
// Assertion macros shared by the ray cube hit test checker.
`ifndef RAY_CUBE_HIT_TEST_CORE_DEFINES_SVH
`define RAY_CUBE_HIT_TEST_CORE_DEFINES_SVH
// Asserts that an implication holds at every clock edge outside reset.
`define RCH_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication failed");
// Asserts that a consequent holds in the cycle after an antecedent.
`define RCH_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`endif

// ===== rtl/rch_pkg.sv =====
// Package with the constants and triangle table of the ray cube hit test.
package rch_pkg;
   localparam int COORD_BITS_DEFAULT = 16;
   localparam int TRIANGLE_COUNT = 12;
   localparam int VERTEX_COUNT = 8;
   localparam int FRAC_BITS = 8;
   localparam int EPS_INV = 100000;
   localparam int CSR_INDEX_BITS = 3;
   localparam int PIPE_DEPTH = 6;

   function automatic logic [2:0] corner_of(input int tri_idx, input int pos);
      logic [2:0] table_v [0:11][0:2];
      table_v = '{'{3'd6, 3'd5, 3'd7}, '{3'd4, 3'd5, 3'd7}, '{3'd0, 3'd4, 3'd7},
                  '{3'd0, 3'd3, 3'd7}, '{3'd4, 3'd1, 3'd5}, '{3'd4, 3'd1, 3'd0},
                  '{3'd6, 3'd1, 3'd2}, '{3'd6, 3'd1, 3'd5}, '{3'd2, 3'd6, 3'd7},
                  '{3'd2, 3'd3, 3'd7}, '{3'd2, 3'd1, 3'd3}, '{3'd0, 3'd1, 3'd3}};
      return table_v[tri_idx][pos];
   endfunction
endpackage

// ===== rtl/rch_tri_pipe.sv =====
// Pipelined Moller-Trumbore test of one ray against one triangle.
module rch_tri_pipe #(
   parameter int COORD_BITS = rch_pkg::COORD_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic signed [COORD_BITS-1:0] o_x, o_y, o_z,
   input  logic signed [COORD_BITS-1:0] d_x, d_y, d_z,
   input  logic signed [COORD_BITS-1:0] p0_x, p0_y, p0_z,
   input  logic signed [COORD_BITS-1:0] p1_x, p1_y, p1_z,
   input  logic signed [COORD_BITS-1:0] p2_x, p2_y, p2_z,
   output logic                          hit
);
   import rch_pkg::*;
   localparam int EW = COORD_BITS + 1;
   localparam int PW = 2 * EW + 1;
   localparam int CW = PW + 1;
   localparam int MW = EW + CW;
   localparam int DW = MW + 2;
   localparam int KW = DW + 18;
   localparam logic [KW-1:0] ONE_UNIT = KW'(1) << (3 * FRAC_BITS);

   // Stage 1: edge vectors.
   logic signed [EW-1:0] e1_ff [3], e2_ff [3], s_ff [3], d1_ff [3];
   always_ff @(posedge clock) begin
      e1_ff[0] <= EW'(p1_x) - EW'(p0_x);
      e1_ff[1] <= EW'(p1_y) - EW'(p0_y);
      e1_ff[2] <= EW'(p1_z) - EW'(p0_z);
      e2_ff[0] <= EW'(p2_x) - EW'(p0_x);
      e2_ff[1] <= EW'(p2_y) - EW'(p0_y);
      e2_ff[2] <= EW'(p2_z) - EW'(p0_z);
      s_ff[0]  <= EW'(o_x) - EW'(p0_x);
      s_ff[1]  <= EW'(o_y) - EW'(p0_y);
      s_ff[2]  <= EW'(o_z) - EW'(p0_z);
      d1_ff[0] <= EW'(d_x);
      d1_ff[1] <= EW'(d_y);
      d1_ff[2] <= EW'(d_z);
   end

   // Stage 2: cross products h = d x e2 and q = s x e1.
   logic signed [CW-1:0] h_ff [3], q_ff [3];
   logic signed [EW-1:0] e1b_ff [3], e2b_ff [3], sb_ff [3], db_ff [3];
   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         h_ff[k] <= CW'(d1_ff[(k+1)%3] * e2_ff[(k+2)%3])
                  - CW'(d1_ff[(k+2)%3] * e2_ff[(k+1)%3]);
         q_ff[k] <= CW'(s_ff[(k+1)%3] * e1_ff[(k+2)%3])
                  - CW'(s_ff[(k+2)%3] * e1_ff[(k+1)%3]);
         e1b_ff[k] <= e1_ff[k];
         e2b_ff[k] <= e2_ff[k];
         sb_ff[k]  <= s_ff[k];
         db_ff[k]  <= d1_ff[k];
      end
   end

   // Stage 3: products for the four dot products.
   logic signed [MW-1:0] pa_ff [3], pu_ff [3], pv_ff [3], pt_ff [3];
   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         pa_ff[k] <= MW'(e1b_ff[k] * h_ff[k]);
         pu_ff[k] <= MW'(sb_ff[k] * h_ff[k]);
         pv_ff[k] <= MW'(db_ff[k] * q_ff[k]);
         pt_ff[k] <= MW'(e2b_ff[k] * q_ff[k]);
      end
   end

   // Stage 4: sums and sign normalization.
   logic signed [DW-1:0] a_in, u_in, v_in, t_in;
   logic signed [DW-1:0] a_ff, u_ff, v_ff, t_ff;
   always_comb begin
      a_in = DW'(pa_ff[0]) + DW'(pa_ff[1]) + DW'(pa_ff[2]);
      u_in = DW'(pu_ff[0]) + DW'(pu_ff[1]) + DW'(pu_ff[2]);
      v_in = DW'(pv_ff[0]) + DW'(pv_ff[1]) + DW'(pv_ff[2]);
      t_in = DW'(pt_ff[0]) + DW'(pt_ff[1]) + DW'(pt_ff[2]);
      if (a_in < 0) begin
         a_in = -a_in;
         u_in = -u_in;
         v_in = -v_in;
         t_in = -t_in;
      end
   end
   always_ff @(posedge clock) begin
      a_ff <= a_in;
      u_ff <= u_in;
      v_ff <= v_in;
      t_ff <= t_in;
   end

   // Stage 5: epsilon scaling and range checks.
   logic signed [KW-1:0] ak_in, tk_in;
   logic range_ok_in, range_ok_ff, det_ok_ff, t_ok_ff;
   always_comb begin
      ak_in = KW'(a_ff) * KW'(EPS_INV);
      tk_in = KW'(t_ff) * KW'(EPS_INV);
      range_ok_in = (u_ff >= 0) && (u_ff <= a_ff) && (v_ff >= 0)
                 && ((u_ff + v_ff) <= a_ff) && (t_ff > 0);
   end
   always_ff @(posedge clock) begin
      range_ok_ff <= range_ok_in;
      det_ok_ff   <= ak_in >= $signed(ONE_UNIT);
      t_ok_ff     <= tk_in > KW'(a_ff);
   end

   assign hit = range_ok_ff && det_ok_ff && t_ok_ff;
endmodule

// ===== rtl/ray_cube_hit_test_core.sv =====
// Top level of the ray cube hit test: vertex registers and twelve triangle pipelines.
//  channel   | ports                  | handshake
//  request   | req_origin_*, req_dir_*| start high, busy low
//  response  | rsp_hit                | rsp_valid strobe, one cycle
//  config    | csr_write, csr_index   | csr_write high, no wait
// Each transaction passes through the triangle pipeline stages and the hit register from start to rsp_valid.
// A new transaction can be started every cycle; busy is always low.
// Reset clears the vertex registers and the valid bits of the pipeline.
// The receiver cannot stall, so results leave the pipeline as they arrive.
module ray_cube_hit_test_core #(
   parameter int COORD_BITS = rch_pkg::COORD_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [COORD_BITS-1:0] req_origin_x,
   input  logic signed [COORD_BITS-1:0] req_origin_y,
   input  logic signed [COORD_BITS-1:0] req_origin_z,
   input  logic signed [COORD_BITS-1:0] req_dir_x,
   input  logic signed [COORD_BITS-1:0] req_dir_y,
   input  logic signed [COORD_BITS-1:0] req_dir_z,
   output logic                          rsp_valid,
   output logic                          rsp_hit,
   input  logic                          csr_write,
   input  logic [rch_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [3*COORD_BITS-1:0]       csr_data
);
   import rch_pkg::*;

   logic [3*COORD_BITS-1:0] vertex_ff [VERTEX_COUNT];
   logic [PIPE_DEPTH-1:0]   valid_ff;
   logic [TRIANGLE_COUNT-1:0] tri_hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < VERTEX_COUNT; i++) begin
            vertex_ff[i] <= '0;
         end
      end else if (csr_write) begin
         vertex_ff[csr_index] <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[PIPE_DEPTH-2:0], start};
      end
   end

   for (genvar t = 0; t < TRIANGLE_COUNT; t++) begin : g_tri
      localparam logic [2:0] C0 = corner_of(t, 0);
      localparam logic [2:0] C1 = corner_of(t, 1);
      localparam logic [2:0] C2 = corner_of(t, 2);
      rch_tri_pipe #(.COORD_BITS(COORD_BITS)) u_tri (
         .clock (clock),
         .o_x (req_origin_x), .o_y (req_origin_y), .o_z (req_origin_z),
         .d_x (req_dir_x), .d_y (req_dir_y), .d_z (req_dir_z),
         .p0_x (vertex_ff[C0][COORD_BITS-1:0]),
         .p0_y (vertex_ff[C0][2*COORD_BITS-1:COORD_BITS]),
         .p0_z (vertex_ff[C0][3*COORD_BITS-1:2*COORD_BITS]),
         .p1_x (vertex_ff[C1][COORD_BITS-1:0]),
         .p1_y (vertex_ff[C1][2*COORD_BITS-1:COORD_BITS]),
         .p1_z (vertex_ff[C1][3*COORD_BITS-1:2*COORD_BITS]),
         .p2_x (vertex_ff[C2][COORD_BITS-1:0]),
         .p2_y (vertex_ff[C2][2*COORD_BITS-1:COORD_BITS]),
         .p2_z (vertex_ff[C2][3*COORD_BITS-1:2*COORD_BITS]),
         .hit (tri_hit[t])
      );
   end

   logic hit_ff;
   always_ff @(posedge clock) begin
      hit_ff <= |tri_hit;
   end

   assign busy      = 1'b0;
   assign rsp_valid = valid_ff[PIPE_DEPTH-1];
   assign rsp_hit   = hit_ff;
endmodule

// ===== rtl/rch_checker.sv =====
// Port-level checker for the ray cube hit test, bound to the top level.
`include "ray_cube_hit_test_core_defines.svh"
module rch_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid,
   input logic rsp_hit
);
   `RCH_ASSERT_IMPLY(a_never_busy, clock, reset, 1'b1, !busy)
   `RCH_ASSERT_IMPLY(a_valid_follows_start, clock, reset,
      rsp_valid, $past(start, 6))
   `RCH_ASSERT_IMPLY(a_start_gives_valid, clock, reset,
      $past(start, 6) && !$past(reset, 6) && !$past(reset, 5) && !$past(reset, 4)
      && !$past(reset, 3) && !$past(reset, 2) && !$past(reset, 1), rsp_valid)
   `RCH_ASSERT_NEXT(a_reset_clears_valid, clock, 1'b0, reset, !rsp_valid)
   `RCH_ASSERT_IMPLY(a_hit_known, clock, reset, rsp_valid, !$isunknown(rsp_hit))
endmodule

bind ray_cube_hit_test_core rch_checker u_rch_checker (
   .clock (clock), .reset (reset), .start (start), .busy (busy),
   .rsp_valid (rsp_valid), .rsp_hit (rsp_hit)
);
